// ===== hdl/vglo_pkg.sv =====
// Package for the voxel gray-level overlay block: widths, register codes,
// pipeline structs and the shared division step. No dependencies.
package vglo_pkg;

    localparam int VAL_W   = 16;
    localparam int SPAN_W  = 16;
    localparam int GRAY_W  = 8;
    localparam int ALPHA_W = 8;
    localparam int OP_W    = 9;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 16;
    localparam int LABEL_W = 8;

    // Divider stages, two quotient bits each
    localparam int DIV_STAGES = GRAY_W / 2;

    localparam logic [OP_W-1:0]    OP_FULL      = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_LIVER  = 8'd128;
    localparam logic [ALPHA_W-1:0] ALPHA_VESSEL = 8'd154;
    localparam logic [ALPHA_W-1:0] ALPHA_TUMOR  = 8'd179;
    localparam logic [GRAY_W-1:0]  GRAY_MAX     = 8'd255;
    localparam logic [GRAY_W-1:0]  OPAQUE       = 8'd255;

    localparam logic [LABEL_W-1:0] LABEL_LIVER  = 8'd1;
    localparam logic [LABEL_W-1:0] LABEL_VESSEL = 8'd2;
    localparam logic [LABEL_W-1:0] LABEL_TUMOR  = 8'd3;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_RANGE_LOW    = 8'd0,
        CFG_RANGE_HIGH   = 8'd1,
        CFG_MASK_OPACITY = 8'd2,
        CFG_SHOW_MASK    = 8'd3
    } t_cfg_idx;

    // How the gray level of an item is finally picked
    typedef enum logic [1:0] {
        GRAY_ZERO = 2'd0,
        GRAY_FULL = 2'd1,
        GRAY_DIV  = 2'd2
    } t_gray_sel;

    typedef struct packed {
        logic [VAL_W-1:0] range_low;
        logic [VAL_W-1:0] range_high;
        logic [OP_W-1:0]  mask_opacity;
        logic             show_mask;
    } t_cfg;

    typedef struct packed {
        logic [VAL_W-1:0]   voxel_value;
        logic               value_finite;
        logic               in_volume;
        logic [LABEL_W-1:0] mask_label;
        logic               mask_covered;
    } t_pix_in;

    // Item traveling through the divider stages
    typedef struct packed {
        logic                valid;
        t_gray_sel           sel;
        logic [SPAN_W-1:0]   span;
        logic [SPAN_W-1:0]   rem;
        logic [GRAY_W-1:0]   bits;
        logic [GRAY_W-1:0]   quo;
        logic [ALPHA_W-1:0]  alpha;
        logic                col_r;
        logic                col_g;
    } t_div_item;

    typedef struct packed {
        logic              valid;
        logic [GRAY_W-1:0] blue;
        logic [GRAY_W-1:0] green;
        logic [GRAY_W-1:0] red;
    } t_pix_out;

    // One restoring division step: brings in the next dividend bit,
    // subtracts the divisor when it fits and shifts in one quotient bit.
    function automatic t_div_item div_step(input t_div_item it);
        t_div_item          res;
        logic [SPAN_W:0]    rem2;
        logic [SPAN_W:0]    diff;
        logic               ge;
        res  = it;
        rem2 = {it.rem, it.bits[GRAY_W-1]};
        diff = rem2 - {1'b0, it.span};
        ge   = (rem2 >= {1'b0, it.span});
        res.rem  = ge ? diff[SPAN_W-1:0] : rem2[SPAN_W-1:0];
        res.bits = {it.bits[GRAY_W-2:0], 1'b0};
        res.quo  = {it.quo[GRAY_W-2:0], ge};
        return res;
    endfunction

endpackage

// ===== hdl/vglo_if.sv =====
// Channel interfaces of the voxel gray-level overlay block: pixel input,
// pixel output and configuration write. Depends on vglo_pkg.
interface vglo_pix_in_if;
    logic                        valid;
    logic                        ready;
    logic [vglo_pkg::VAL_W-1:0]  voxel_value;
    logic                        value_finite;
    logic                        in_volume;
    logic [vglo_pkg::LABEL_W-1:0] mask_label;
    logic                        mask_covered;

    modport source (output valid, voxel_value, value_finite, in_volume, mask_label,
                    mask_covered, input ready);
    modport sink (input valid, voxel_value, value_finite, in_volume, mask_label,
                  mask_covered, output ready);
endinterface

interface vglo_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [vglo_pkg::GRAY_W-1:0]  blue;
    logic [vglo_pkg::GRAY_W-1:0]  green;
    logic [vglo_pkg::GRAY_W-1:0]  red;
    logic [vglo_pkg::GRAY_W-1:0]  opacity_out;

    modport source (output valid, blue, green, red, opacity_out, input ready);
    modport sink (input valid, blue, green, red, opacity_out, output ready);
endinterface

interface vglo_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [vglo_pkg::IDX_W-1:0]  index;
    logic [vglo_pkg::CFG_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/vglo_prep.sv =====
// Front stage: window offset, span, numerator d*255, gray class and overlay
// alpha. Depends on vglo_pkg.
module vglo_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  vglo_pkg::t_pix_in   i_pix,
    input  vglo_pkg::t_cfg      i_cfg,
    output vglo_pkg::t_div_item o_item
);

    vglo_pkg::t_div_item r_item;
    vglo_pkg::t_div_item n_item;

    logic                          win_ok;
    logic [vglo_pkg::VAL_W-1:0]    eff_lo;
    logic [vglo_pkg::VAL_W-1:0]    eff_hi;
    logic [vglo_pkg::VAL_W:0]      span17;
    logic [vglo_pkg::VAL_W:0]      d17;
    logic                          below;
    logic                          above;
    logic [23:0]                   num;
    logic                          overlay;
    logic [vglo_pkg::ALPHA_W-1:0]  ac;
    logic                          cr;
    logic                          cg;
    logic [vglo_pkg::OP_W-1:0]     op;
    logic [16:0]                   prod;

    // Window: an empty or inverted one falls back to 0..1
    always_comb begin
        win_ok = $signed(i_cfg.range_high) > $signed(i_cfg.range_low);
        eff_lo = win_ok ? i_cfg.range_low : '0;
        eff_hi = win_ok ? i_cfg.range_high : 16'd1;
        span17 = {eff_hi[vglo_pkg::VAL_W-1], eff_hi} - {eff_lo[vglo_pkg::VAL_W-1], eff_lo};
        d17    = {i_pix.voxel_value[vglo_pkg::VAL_W-1], i_pix.voxel_value}
               - {eff_lo[vglo_pkg::VAL_W-1], eff_lo};
        below  = d17[vglo_pkg::VAL_W] || (d17 == '0);
        above  = !d17[vglo_pkg::VAL_W] && (d17[vglo_pkg::VAL_W-1:0] >= span17[vglo_pkg::VAL_W-1:0]);
        // d*255 as d*256 - d
        num    = {d17[vglo_pkg::VAL_W-1:0], 8'd0} - {8'd0, d17[vglo_pkg::VAL_W-1:0]};
    end

    // Class color and alpha
    always_comb begin
        overlay = i_cfg.show_mask && i_pix.mask_covered && i_pix.in_volume;
        ac      = '0;
        cr      = 1'b0;
        cg      = 1'b0;
        case (i_pix.mask_label)
            vglo_pkg::LABEL_LIVER: begin
                ac = vglo_pkg::ALPHA_LIVER;
                cg = 1'b1;
            end
            vglo_pkg::LABEL_VESSEL: begin
                ac = vglo_pkg::ALPHA_VESSEL;
                cr = 1'b1;
            end
            vglo_pkg::LABEL_TUMOR: begin
                ac = vglo_pkg::ALPHA_TUMOR;
                cr = 1'b1;
                cg = 1'b1;
            end
            default: overlay = 1'b0;
        endcase
        op   = (i_cfg.mask_opacity > vglo_pkg::OP_FULL) ? vglo_pkg::OP_FULL
                                                        : i_cfg.mask_opacity;
        prod = ac * op;
    end

    // Next stage contents
    always_comb begin
        n_item       = '0;
        n_item.valid = i_valid;
        n_item.span  = span17[vglo_pkg::SPAN_W-1:0];
        n_item.rem   = num[23:8];
        n_item.bits  = num[7:0];
        n_item.quo   = '0;
        if (!(i_pix.value_finite && i_pix.in_volume) || below) begin
            n_item.sel = vglo_pkg::GRAY_ZERO;
        end else if (above) begin
            n_item.sel = vglo_pkg::GRAY_FULL;
        end else begin
            n_item.sel = vglo_pkg::GRAY_DIV;
        end
        if (overlay) begin
            n_item.alpha = prod[15:8];
            n_item.col_r = cr;
            n_item.col_g = cg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/vglo_div_stage.sv =====
// Divider stage: two restoring division steps and a pipeline register.
// Depends on vglo_pkg.
module vglo_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  vglo_pkg::t_div_item i_item,
    output vglo_pkg::t_div_item o_item
);

    vglo_pkg::t_div_item r_item;
    vglo_pkg::t_div_item n_item;

    // Two quotient bits per stage
    always_comb begin
        n_item = vglo_pkg::div_step(vglo_pkg::div_step(i_item));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/vglo_blend.sv =====
// Output stage: gray pick, alpha blend toward the class color, output
// register. Depends on vglo_pkg.
module vglo_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  vglo_pkg::t_div_item i_item,
    output vglo_pkg::t_pix_out  o_pix
);

    vglo_pkg::t_pix_out r_out;
    vglo_pkg::t_pix_out n_out;

    logic [vglo_pkg::GRAY_W-1:0] gray;
    logic [vglo_pkg::OP_W-1:0]   inv;
    logic [16:0]                 base;
    logic [15:0]                 add;
    logic [16:0]                 sum_g;
    logic [16:0]                 sum_r;

    // gray*(256-a) + 255*a per colored channel; alpha is 0 without overlay
    always_comb begin
        case (i_item.sel)
            vglo_pkg::GRAY_DIV:  gray = i_item.quo;
            vglo_pkg::GRAY_FULL: gray = vglo_pkg::GRAY_MAX;
            default:             gray = '0;
        endcase
        inv   = vglo_pkg::OP_FULL - {1'b0, i_item.alpha};
        base  = gray * inv;
        add   = {i_item.alpha, 8'd0} - {8'd0, i_item.alpha};
        sum_g = base + (i_item.col_g ? {1'b0, add} : 17'd0);
        sum_r = base + (i_item.col_r ? {1'b0, add} : 17'd0);
        n_out.valid = i_item.valid;
        n_out.blue  = base[15:8];
        n_out.green = sum_g[15:8];
        n_out.red   = sum_r[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_pix = r_out;

endmodule

// ===== hdl/voxel_gray_label_overlay_top.sv =====
// Top level of the voxel gray-level overlay block: config registers and the
// six-stage pipeline. Depends on vglo_pkg, vglo_if, vglo_prep, vglo_div_stage, vglo_blend.

// Maps each signed voxel sample through the window [range_low, range_high]
// to gray 0..255 and blends labeled voxels toward green, red or yellow. The
// block takes one voxel per clock unless the output is stalled and returns
// one BGRA pixel per voxel after a front stage, four divider stages that each
// resolve two quotient bits of (v-low)*255/(high-low), and the blend stage
// with the output register. The whole pipeline holds while a result waits
// to be taken, so i_pix.ready follows o_pix.ready whenever o_pix.valid is
// high. Configuration writes are always taken and apply to voxels that
// transfer in after them.
module voxel_gray_label_overlay_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vglo_pix_in_if.sink           i_pix,
    vglo_pix_out_if.source        o_pix,
    vglo_cfg_if.sink              i_cfg
);

    vglo_pkg::t_cfg      r_cfg;
    vglo_pkg::t_pix_in   pix_in;
    vglo_pkg::t_div_item stage [vglo_pkg::DIV_STAGES+1];
    vglo_pkg::t_pix_out  pix_out;
    logic                en;

    // Config register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low    <= '0;
            r_cfg.range_high   <= 16'd1;
            r_cfg.mask_opacity <= 9'd128;
            r_cfg.show_mask    <= 1'b1;
        end else if (i_cfg.valid) begin
            case (vglo_pkg::t_cfg_idx'(i_cfg.index))
                vglo_pkg::CFG_RANGE_LOW:    r_cfg.range_low    <= i_cfg.data;
                vglo_pkg::CFG_RANGE_HIGH:   r_cfg.range_high   <= i_cfg.data;
                vglo_pkg::CFG_MASK_OPACITY: r_cfg.mask_opacity <= i_cfg.data[vglo_pkg::OP_W-1:0];
                vglo_pkg::CFG_SHOW_MASK:    r_cfg.show_mask    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a finished pixel is held at the output
    assign en          = !(pix_out.valid && !o_pix.ready);
    assign i_pix.ready = en;

    always_comb begin
        pix_in.voxel_value  = i_pix.voxel_value;
        pix_in.value_finite = i_pix.value_finite;
        pix_in.in_volume    = i_pix.in_volume;
        pix_in.mask_label   = i_pix.mask_label;
        pix_in.mask_covered = i_pix.mask_covered;
    end

    vglo_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_pix   (pix_in),
        .i_cfg   (r_cfg),
        .o_item  (stage[0])
    );

    for (genvar g = 0; g < vglo_pkg::DIV_STAGES; g++) begin : g_div
        vglo_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (stage[g]),
            .o_item  (stage[g+1])
        );
    end

    vglo_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (stage[vglo_pkg::DIV_STAGES]),
        .o_pix   (pix_out)
    );

    assign o_pix.valid       = pix_out.valid;
    assign o_pix.blue        = pix_out.blue;
    assign o_pix.green       = pix_out.green;
    assign o_pix.red         = pix_out.red;
    assign o_pix.opacity_out = vglo_pkg::OPAQUE;

    // A held output pixel stops the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input ready while output is stalled");

    // An empty output register never blocks the input
    a_free_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pix.valid |-> i_pix.ready)
        else $error("input not ready with empty output register");

    // Blue is never tinted, so it cannot exceed green or red
    a_blue_lowest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.blue <= o_pix.green) && (o_pix.blue <= o_pix.red))
        else $error("blue channel above a tinted channel");

endmodule

// ===== verif/tb_voxel_gray_label_overlay_top.sv =====
// Testbench for voxel_gray_label_overlay_top: drives voxels and register writes,
// predicts every BGRA pixel and compares it with the block's output in order.
// Depends on vglo_pkg, vglo_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_voxel_gray_label_overlay_top;

    typedef struct packed {
        logic [vglo_pkg::GRAY_W-1:0] blue;
        logic [vglo_pkg::GRAY_W-1:0] green;
        logic [vglo_pkg::GRAY_W-1:0] red;
        logic [vglo_pkg::GRAY_W-1:0] opacity_out;
    } t_bgra;

    typedef struct {
        logic [vglo_pkg::IDX_W-1:0] index;
        logic [vglo_pkg::CFG_W-1:0] data;
    } t_reg_write;

    localparam int PHASES       = 30;
    localparam int PHASE_VOXELS = 51;
    localparam int MAX_WAIT     = 19;
    localparam int PRINT_CAP    = 40;

    logic i_clk;
    logic i_rst_n;

    vglo_pix_in_if  pix_in ();
    vglo_pix_out_if pix_out ();
    vglo_cfg_if     cfg_bus ();

    voxel_gray_label_overlay_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_bus)
    );

    // Pending stimulus and predicted pixels
    vglo_pkg::t_pix_in voxel_queue[$];
    t_bgra             expected_pixels[$];
    t_reg_write        reg_writes[$];

    // Shadow copy of the configuration registers
    logic [vglo_pkg::VAL_W-1:0] win_low;
    logic [vglo_pkg::VAL_W-1:0] win_high;
    logic [vglo_pkg::OP_W-1:0]  overlay_opacity;
    logic                       overlay_on;

    vglo_pkg::t_pix_in cur_voxel;
    int      gap_left;
    int      stall_left;
    bit      no_idle;
    int      err_count;
    int      sent_voxels;
    int      checked_pixels;
    int      written_regs;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_CAP)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic int unsigned mix_channel(input int unsigned gray, input logic tint,
                                                input int unsigned alpha);
        return (gray * (256 - alpha) + int'(tint) * 255 * alpha) >> 8;
    endfunction

    // Gray windowing and label tint of one voxel under the shadow configuration
    function automatic t_bgra shade_voxel(input vglo_pkg::t_pix_in px);
        int          lo;
        int          hi;
        int          d;
        int          span;
        int unsigned gray;
        int unsigned op;
        int unsigned ac;
        int unsigned alpha;
        logic        tint_r;
        logic        tint_g;
        bit          tinted;
        t_bgra       pix;
        lo = int'($signed(win_low));
        hi = int'($signed(win_high));
        if (hi <= lo) begin
            lo = 0;
            hi = 1;
        end
        gray = 0;
        if (px.value_finite && px.in_volume) begin
            d    = int'($signed(px.voxel_value)) - lo;
            span = hi - lo;
            if (d >= span)
                gray = vglo_pkg::GRAY_MAX;
            else if (d > 0)
                gray = unsigned'((d * int'(vglo_pkg::GRAY_MAX)) / span);
        end
        pix.blue        = 8'(gray);
        pix.green       = 8'(gray);
        pix.red         = 8'(gray);
        pix.opacity_out = vglo_pkg::OPAQUE;
        tinted = 1'b1;
        ac     = 0;
        tint_r = 1'b0;
        tint_g = 1'b0;
        case (px.mask_label)
            vglo_pkg::LABEL_LIVER: begin
                ac     = vglo_pkg::ALPHA_LIVER;
                tint_g = 1'b1;
            end
            vglo_pkg::LABEL_VESSEL: begin
                ac     = vglo_pkg::ALPHA_VESSEL;
                tint_r = 1'b1;
            end
            vglo_pkg::LABEL_TUMOR: begin
                ac     = vglo_pkg::ALPHA_TUMOR;
                tint_r = 1'b1;
                tint_g = 1'b1;
            end
            default: tinted = 1'b0;
        endcase
        if (overlay_on && px.mask_covered && px.in_volume && tinted) begin
            op    = (overlay_opacity > vglo_pkg::OP_FULL) ? vglo_pkg::OP_FULL : overlay_opacity;
            alpha = (ac * op) >> 8;
            pix.red   = 8'(mix_channel(gray, tint_r, alpha));
            pix.green = 8'(mix_channel(gray, tint_g, alpha));
            pix.blue  = 8'(mix_channel(gray, 1'b0, alpha));
        end
        return pix;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // Register write driver; the shadow registers follow each transfer
    always @(posedge i_clk) begin
        t_reg_write w;
        if (!i_rst_n) begin
            cfg_bus.valid   <= 1'b0;
            win_low         = '0;
            win_high        = 16'd1;
            overlay_opacity = 9'd128;
            overlay_on      = 1'b1;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                written_regs++;
                case (cfg_bus.index)
                    vglo_pkg::CFG_RANGE_LOW:    win_low = cfg_bus.data;
                    vglo_pkg::CFG_RANGE_HIGH:   win_high = cfg_bus.data;
                    vglo_pkg::CFG_MASK_OPACITY:
                        overlay_opacity = cfg_bus.data[vglo_pkg::OP_W-1:0];
                    vglo_pkg::CFG_SHOW_MASK:    overlay_on = cfg_bus.data[0];
                    default: ;
                endcase
            end
            if (!cfg_bus.valid || cfg_bus.ready) begin
                if (reg_writes.size() > 0) begin
                    w = reg_writes.pop_front();
                    cfg_bus.valid <= 1'b1;
                    cfg_bus.index <= w.index;
                    cfg_bus.data  <= w.data;
                end else begin
                    cfg_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Voxel driver: predicts each voxel on its transfer, then waits out a drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
            gap_left     = 0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                expected_pixels.push_back(shade_voxel(cur_voxel));
                sent_voxels++;
            end
            if (!pix_in.valid || pix_in.ready) begin
                if (gap_left > 0) begin
                    pix_in.valid <= 1'b0;
                    gap_left--;
                end else if (voxel_queue.size() > 0) begin
                    cur_voxel = voxel_queue.pop_front();
                    pix_in.valid        <= 1'b1;
                    pix_in.voxel_value  <= cur_voxel.voxel_value;
                    pix_in.value_finite <= cur_voxel.value_finite;
                    pix_in.in_volume    <= cur_voxel.in_volume;
                    pix_in.mask_label   <= cur_voxel.mask_label;
                    pix_in.mask_covered <= cur_voxel.mask_covered;
                    gap_left = draw_wait();
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor with random back-pressure
    always @(posedge i_clk) begin
        t_bgra want;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with nothing pending", pix_out.blue, -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (pix_out.blue !== want.blue)
                        report_mismatch("blue", pix_out.blue, want.blue);
                    if (pix_out.green !== want.green)
                        report_mismatch("green", pix_out.green, want.green);
                    if (pix_out.red !== want.red)
                        report_mismatch("red", pix_out.red, want.red);
                    if (pix_out.opacity_out !== want.opacity_out)
                        report_mismatch("opacity_out", pix_out.opacity_out, want.opacity_out);
                end
                checked_pixels++;
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                pix_out.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    function automatic bit block_busy();
        return voxel_queue.size() != 0 || expected_pixels.size() != 0 ||
               reg_writes.size() != 0 || pix_in.valid || cfg_bus.valid;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk); while (block_busy());
    endtask

    task automatic queue_write(input logic [vglo_pkg::IDX_W-1:0] index,
                               input logic [vglo_pkg::CFG_W-1:0] data);
        t_reg_write w;
        w.index = index;
        w.data  = data;
        reg_writes.push_back(w);
    endtask

    // Full register set, applied only while nothing is in flight
    task automatic set_config(input int lo, input int hi,
                              input logic [vglo_pkg::CFG_W-1:0] op_data,
                              input logic [vglo_pkg::CFG_W-1:0] show_data);
        wait_idle();
        queue_write(vglo_pkg::CFG_RANGE_LOW, lo[vglo_pkg::CFG_W-1:0]);
        queue_write(vglo_pkg::CFG_RANGE_HIGH, hi[vglo_pkg::CFG_W-1:0]);
        queue_write(vglo_pkg::CFG_MASK_OPACITY, op_data);
        queue_write(vglo_pkg::CFG_SHOW_MASK, show_data);
        wait_idle();
    endtask

    task automatic add_voxel(input int v, input logic finite, input logic in_vol,
                             input logic [vglo_pkg::LABEL_W-1:0] label, input logic covered);
        vglo_pkg::t_pix_in px;
        px.voxel_value  = v[vglo_pkg::VAL_W-1:0];
        px.value_finite = finite;
        px.in_volume    = in_vol;
        px.mask_label   = label;
        px.mask_covered = covered;
        voxel_queue.push_back(px);
    endtask

    function automatic int clamp16(input int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    // Samples fall mostly in and just around the effective window, some on its edges or extremes, some anywhere
    function automatic int pick_sample(input int lo, input int hi);
        int eff_lo;
        int eff_hi;
        int v;
        eff_lo = lo;
        eff_hi = hi;
        if (hi <= lo) begin
            eff_lo = 0;
            eff_hi = 1;
        end
        case ($urandom_range(0, 7))
            0, 1: v = int'($urandom_range(0, 65535)) - 32768;
            2: begin
                case ($urandom_range(0, 5))
                    0: v = eff_lo;
                    1: v = eff_hi;
                    2: v = eff_lo - 1;
                    3: v = eff_hi + 1;
                    4: v = -32768;
                    default: v = 32767;
                endcase
            end
            default: v = eff_lo - 2 + int'($urandom_range(0, eff_hi - eff_lo + 4));
        endcase
        return clamp16(v);
    endfunction

    function automatic logic [vglo_pkg::LABEL_W-1:0] pick_label();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3));
    endfunction

    // Stimulus
    initial begin
        int lo;
        int hi;
        int op;
        logic [vglo_pkg::CFG_W-1:0] op_data;
        logic [vglo_pkg::CFG_W-1:0] show_data;
        int drain;

        i_rst_n             = 1'b0;
        pix_in.valid        = 1'b0;
        pix_in.voxel_value  = '0;
        pix_in.value_finite = 1'b0;
        pix_in.in_volume    = 1'b0;
        pix_in.mask_label   = '0;
        pix_in.mask_covered = 1'b0;
        pix_out.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        err_count      = 0;
        sent_voxels    = 0;
        checked_pixels = 0;
        written_regs   = 0;
        no_idle        = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: window 0..1, half opacity, overlay on
        add_voxel(0, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(1, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(-32768, 1'b1, 1'b1, vglo_pkg::LABEL_LIVER, 1'b1);
        add_voxel(32767, 1'b1, 1'b1, vglo_pkg::LABEL_TUMOR, 1'b1);

        // Ordinary window, full opacity, plus a write to an unused index
        set_config(-100, 1000, 16'd256, 16'd1);
        wait_idle();
        queue_write(8'(vglo_pkg::CFG_SHOW_MASK) + 8'd197, 16'hA5A5);
        wait_idle();
        add_voxel(-100, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(1000, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(999, 1'b1, 1'b1, 8'd0, 1'b1);
        add_voxel(-99, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(450, 1'b1, 1'b1, vglo_pkg::LABEL_LIVER, 1'b1);
        add_voxel(450, 1'b1, 1'b1, vglo_pkg::LABEL_VESSEL, 1'b1);
        add_voxel(450, 1'b1, 1'b1, vglo_pkg::LABEL_TUMOR, 1'b1);
        add_voxel(450, 1'b1, 1'b1, vglo_pkg::LABEL_LIVER, 1'b0);
        add_voxel(450, 1'b1, 1'b1, 8'd4, 1'b1);
        add_voxel(450, 1'b1, 1'b1, 8'd255, 1'b1);
        // non-finite keeps the tint, outside the volume drops it
        add_voxel(700, 1'b0, 1'b1, vglo_pkg::LABEL_VESSEL, 1'b1);
        add_voxel(700, 1'b1, 1'b0, vglo_pkg::LABEL_VESSEL, 1'b1);
        add_voxel(-32768, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(32767, 1'b1, 1'b1, 8'd0, 1'b0);

        // Widest window, opacity beyond full with junk upper bits, overlay off
        set_config(-32768, 32767, 16'hFFFF, 16'hFFFE);
        add_voxel(-32768, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(32767, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(0, 1'b1, 1'b1, vglo_pkg::LABEL_TUMOR, 1'b1);

        // Empty window falls back to 0..1, zero opacity
        set_config(300, 300, 16'd0, 16'd1);
        add_voxel(0, 1'b1, 1'b1, 8'd0, 1'b0);
        add_voxel(1, 1'b1, 1'b1, vglo_pkg::LABEL_LIVER, 1'b1);
        add_voxel(-5, 1'b1, 1'b1, 8'd0, 1'b0);

        // Inverted window at the extremes
        set_config(32767, -32768, 16'd256, 16'd1);
        add_voxel(1, 1'b1, 1'b1, vglo_pkg::LABEL_TUMOR, 1'b1);

        // Random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0: begin
                    lo = -32768;
                    hi = 32767;
                end
                1: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = int'($urandom_range(0, 65535)) - 32768;
                end
                2: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = clamp16(lo + int'($urandom_range(1, 300)));
                end
                3: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = clamp16(lo - int'($urandom_range(0, 50)));
                end
                4: begin
                    lo = int'($urandom_range(0, 20)) - 10;
                    hi = lo + int'($urandom_range(1, 20));
                end
                default: begin
                    lo = int'($urandom_range(0, 2000)) - 1000;
                    hi = lo + int'($urandom_range(1, 2000));
                end
            endcase
            case ($urandom_range(0, 4))
                0: op = 0;
                1: op = 256;
                2: op = int'($urandom_range(257, 511));
                3: op = 128;
                default: op = int'($urandom_range(0, 256));
            endcase
            op_data   = 16'(($urandom_range(0, 65535) & 16'hFE00) | op[vglo_pkg::OP_W-1:0]);
            show_data = 16'(($urandom_range(0, 65535) & 16'hFFFE) |
                            ($urandom_range(0, 3) != 0));
            set_config(lo, hi, op_data, show_data);
            if ($urandom_range(0, 3) == 0) begin
                queue_write(8'($urandom_range(int'(vglo_pkg::CFG_SHOW_MASK) + 1, 255)),
                            16'($urandom_range(0, 65535)));
                wait_idle();
            end
            no_idle = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < PHASE_VOXELS; k++)
                add_voxel(pick_sample(lo, hi), $urandom_range(0, 7) != 0,
                          $urandom_range(0, 7) != 0, pick_label(), $urandom_range(0, 3) != 0);
        end

        // Drain, then watch a while longer for stray pixels
        drain = 0;
        while ((block_busy()) && drain < 5000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (20) @(negedge i_clk);
        if (expected_pixels.size() != 0)
            report_mismatch("pixels never delivered", 0, expected_pixels.size());

        $display("Sent %0d voxels over %0d register settings, %0d register writes,",
                 sent_voxels, PHASES + 5, written_regs);
        $display("and checked %0d pixels; %0d mismatches.", checked_pixels, err_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== voxel_gray_label_overlay_top.f =====
hdl/vglo_pkg.sv
hdl/vglo_if.sv
hdl/vglo_prep.sv
hdl/vglo_div_stage.sv
hdl/vglo_blend.sv
hdl/voxel_gray_label_overlay_top.sv
verif/tb_voxel_gray_label_overlay_top.sv
